// ===== rtl/dqpc_pkg.sv =====
package dqpc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int TIME_W          = 32;
	localparam int GAP_W           = 16;
	localparam int FACTOR_W        = 10;
	localparam int STEP_W          = 11;
	localparam int REG_IDX_W       = 3;
	localparam int IN_TDATA_W      = 40;

	localparam logic [GAP_W-1:0]    SETTLE_RST = 16'd100;
	localparam logic [GAP_W-1:0]    GAP_RST    = 16'd1000;
	localparam logic [FACTOR_W-1:0] FACTOR_RST = 10'd1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SETTLE,
		REG_GAP,
		REG_FACTOR,
		REG_LOWER,
		REG_UPPER,
		REG_MODE
	} reg_idx_t;

	typedef enum logic {
		MODE_BOTH,
		MODE_FALL
	} mode_t;

	typedef struct packed {
		logic [GAP_W-1:0]    settle_us;
		logic [GAP_W-1:0]    gap_us;
		logic [FACTOR_W-1:0] factor;
		mode_t               mode;
	} cfg_t;

endpackage

// ===== rtl/dqpc_cfg.sv =====
module dqpc_cfg #(
	parameter int VALUE_WIDTH = 32,
	parameter int DATA_W      = (VALUE_WIDTH > 32) ? 64 : 32,
	parameter int ADDR_SHIFT  = (VALUE_WIDTH > 32) ? 3 : 2,
	parameter int ADDR_W      = dqpc_pkg::REG_IDX_W + ADDR_SHIFT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	output dqpc_pkg::cfg_t                cfg,
	output logic signed [VALUE_WIDTH-1:0] lower_limit,
	output logic signed [VALUE_WIDTH-1:0] upper_limit
);
	import dqpc_pkg::*;

	cfg_t                          cfg_q;
	logic signed [VALUE_WIDTH-1:0] lower_q;
	logic signed [VALUE_WIDTH-1:0] upper_q;
	reg_idx_t                      idx;
	logic                          wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_SHIFT]);
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_us <= SETTLE_RST;
			cfg_q.gap_us    <= GAP_RST;
			cfg_q.factor    <= FACTOR_RST;
			cfg_q.mode      <= MODE_BOTH;
			lower_q         <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			upper_q         <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end else if (wr) begin
			case (idx)
				REG_SETTLE: cfg_q.settle_us <= pwdata[GAP_W-1:0];
				REG_GAP:    cfg_q.gap_us    <= pwdata[GAP_W-1:0];
				REG_FACTOR: cfg_q.factor    <= pwdata[FACTOR_W-1:0];
				REG_LOWER:  lower_q         <= pwdata[VALUE_WIDTH-1:0];
				REG_UPPER:  upper_q         <= pwdata[VALUE_WIDTH-1:0];
				REG_MODE:   cfg_q.mode      <= mode_t'(pwdata[0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETTLE: prdata = DATA_W'(cfg_q.settle_us);
			REG_GAP:    prdata = DATA_W'(cfg_q.gap_us);
			REG_FACTOR: prdata = DATA_W'(cfg_q.factor);
			REG_LOWER:  prdata = DATA_W'(lower_q);
			REG_UPPER:  prdata = DATA_W'(upper_q);
			REG_MODE:   prdata = DATA_W'(cfg_q.mode);
			default:    prdata = '0;
		endcase
	end

	assign cfg         = cfg_q;
	assign lower_limit = lower_q;
	assign upper_limit = upper_q;

endmodule

// ===== rtl/dqpc_core.sv =====
module dqpc_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  phase_a,
	input  logic                                  phase_b,
	input  logic [dqpc_pkg::TIME_W-1:0]           time_us,
	input  dqpc_pkg::cfg_t                        cfg,
	input  logic signed [VALUE_WIDTH-1:0]         lower_limit,
	input  logic signed [VALUE_WIDTH-1:0]         upper_limit,
	output logic signed [VALUE_WIDTH-1:0]         position_value,
	output logic signed [dqpc_pkg::STEP_W-1:0]    last_step,
	output logic                                  moved
);
	import dqpc_pkg::*;

	localparam int SUM_W = ((VALUE_WIDTH > STEP_W) ? VALUE_WIDTH : STEP_W) + 1;

	logic                          raw_prev_q;
	logic                          filt_q;
	logic                          pend_q;
	logic [TIME_W-1:0]             settle_dl_q;
	logic [TIME_W-1:0]             report_dl_q;
	logic signed [VALUE_WIDTH-1:0] pos_q;
	logic signed [STEP_W-1:0]      step_q;

	logic                          settle_fire;
	logic                          raw_chg;
	logic                          filt_n;
	logic                          filt_edge;
	logic                          count;
	logic signed [STEP_W-1:0]      f_pos;
	logic signed [STEP_W-1:0]      st;
	logic signed [SUM_W-1:0]       sum;
	logic signed [SUM_W-1:0]       lo_ext;
	logic signed [SUM_W-1:0]       hi_ext;
	logic signed [SUM_W-1:0]       clamped;

	assign settle_fire = pend_q && (time_us > settle_dl_q);
	assign raw_chg     = phase_a != raw_prev_q;
	assign filt_n      = settle_fire ? phase_a : filt_q;
	assign filt_edge   = filt_n != filt_q;
	assign count       = filt_edge && (time_us > report_dl_q);
	assign f_pos       = $signed({1'b0, cfg.factor});

	always_comb begin
		case (cfg.mode)
			MODE_BOTH: st = (filt_n == phase_b) ? f_pos : -f_pos;
			MODE_FALL: st = filt_n ? '0 : (phase_b ? f_pos : -f_pos);
			default:   st = '0;
		endcase
	end

	// wide sum, raised to lower then lowered to upper
	always_comb begin
		sum     = SUM_W'(pos_q) + SUM_W'(st);
		lo_ext  = SUM_W'(lower_limit);
		hi_ext  = SUM_W'(upper_limit);
		clamped = sum;
		if (clamped < lo_ext)
			clamped = lo_ext;
		if (clamped > hi_ext)
			clamped = hi_ext;
	end

	assign position_value = count ? clamped[VALUE_WIDTH-1:0] : pos_q;
	assign last_step      = count ? st : step_q;
	assign moved          = count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q  <= 1'b0;
			filt_q      <= 1'b0;
			pend_q      <= 1'b0;
			settle_dl_q <= '0;
			report_dl_q <= '0;
			pos_q       <= '0;
			step_q      <= '0;
		end else if (en) begin
			raw_prev_q <= phase_a;
			filt_q     <= filt_n;
			pend_q     <= raw_chg | (pend_q & ~settle_fire);
			if (raw_chg)
				settle_dl_q <= time_us + TIME_W'(cfg.settle_us);
			if (filt_edge)
				report_dl_q <= time_us + TIME_W'(cfg.gap_us);
			pos_q  <= position_value;
			step_q <= last_step;
		end
	end

endmodule

// ===== rtl/debounced_quadrature_position_counter_unit.sv =====
// channel  | dir | beat fields (low bit up)
// s_axis   | in  | tdata: phase_a, phase_b, time_us[31:0]
// m_axis   | out | tdata: position_value, last_step[10:0]; tuser: moved
// apb      | in  | 6 registers at 4*i (8*i when VALUE_WIDTH > 32)
// One beat per clock sustained while m_tready is high; input register, then result register.
// The state update is one pass of compare, add and clamp, so the next beat follows at once.
// arst_n clears state, filter and configuration to their defaults.
// A stalled m_tready holds the result; s_tready drops only when both registers are full.
module debounced_quadrature_position_counter_unit #(
	parameter int VALUE_WIDTH = dqpc_pkg::VALUE_WIDTH_DEF,
	parameter int DATA_W      = (VALUE_WIDTH > 32) ? 64 : 32,
	parameter int ADDR_SHIFT  = (VALUE_WIDTH > 32) ? 3 : 2,
	parameter int ADDR_W      = dqpc_pkg::REG_IDX_W + ADDR_SHIFT,
	parameter int OUT_TDATA_W = ((VALUE_WIDTH + dqpc_pkg::STEP_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ADDR_W-1:0]                 paddr,
	input  logic [DATA_W-1:0]                 pwdata,
	output logic [DATA_W-1:0]                 prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dqpc_pkg::IN_TDATA_W-1:0]   s_tdata,  // phase_a, phase_b, time_us
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_TDATA_W-1:0]            m_tdata,  // position_value, last_step
	output logic                              m_tuser   // moved
);
	import dqpc_pkg::*;

	cfg_t                          cfg;
	logic signed [VALUE_WIDTH-1:0] lower_limit;
	logic signed [VALUE_WIDTH-1:0] upper_limit;

	logic                          vld_s1;
	logic                          a_s1;
	logic                          b_s1;
	logic [TIME_W-1:0]             time_s1;
	logic                          adv;
	logic                          fire;

	logic signed [VALUE_WIDTH-1:0] pos_n;
	logic signed [STEP_W-1:0]      step_n;
	logic                          moved_n;

	logic                          out_vld_q;
	logic signed [VALUE_WIDTH-1:0] pos_q;
	logic signed [STEP_W-1:0]      step_q;
	logic                          moved_q;

	dqpc_cfg #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DATA_W     (DATA_W),
		.ADDR_SHIFT (ADDR_SHIFT),
		.ADDR_W     (ADDR_W)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.lower_limit(lower_limit),
		.upper_limit(upper_limit)
	);

	assign adv      = ~out_vld_q | m_tready;
	assign fire     = vld_s1 & adv;
	assign s_tready = ~vld_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			a_s1    <= s_tdata[0];
			b_s1    <= s_tdata[1];
			time_s1 <= s_tdata[TIME_W+1:2];
		end
	end

	dqpc_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (fire),
		.phase_a       (a_s1),
		.phase_b       (b_s1),
		.time_us       (time_s1),
		.cfg           (cfg),
		.lower_limit   (lower_limit),
		.upper_limit   (upper_limit),
		.position_value(pos_n),
		.last_step     (step_n),
		.moved         (moved_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pos_q   <= pos_n;
			step_q  <= step_n;
			moved_q <= moved_n;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_TDATA_W'({step_q, pos_q});
	assign m_tuser  = moved_q;

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> s_tready)
		else $error("input stalled with empty result register");

	a_moved_within_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && moved_q) |-> (pos_q <= upper_limit))
		else $error("counted position above upper limit");

	a_both_mode_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && moved_q && cfg.mode == MODE_BOTH) |->
		(step_q != '0 || cfg.factor == '0))
		else $error("counted edge in both-edge mode with zero step");

endmodule
